// ===== rtl/mls_pkg.sv =====
// Package for the macro line splitter: result and state types, byte codes,
// the realtime command table and the per-byte helper functions.
// No dependencies; used by mls_out_buf and macro_line_splitter_with_escapes.
package mls_pkg;

  localparam int MaxResults = 6;
  localparam int CntW = $clog2(MaxResults + 1);
  localparam int NumCodes = 17;

  localparam logic [1:0] KIND_BYTE      = 2'd0;
  localparam logic [1:0] KIND_LINE_END  = 2'd1;
  localparam logic [1:0] KIND_COMMAND   = 2'd2;
  localparam logic [1:0] KIND_MACRO_END = 2'd3;

  localparam logic [7:0] CH_ESCAPE  = 8'h23;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [7:0] MaxLineLenReset = 8'd255;

  // Two-character realtime codes, first character in the upper byte.
  localparam logic [15:0] CodeTable [NumCodes] = '{
    "fr", "f>", "f<", "f+", "f-",
    "rr", "rm", "rl", "rx",
    "sr", "s>", "s<", "s+", "s-", "ss",
    "ft", "mt"
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [4:0] cmd;
    logic       st;
    logic [7:0] len;
  } res_t;

  typedef struct packed {
    logic       esc;
    logic       held_one;
    logic [7:0] held0;
    logic [7:0] line_len;
  } mstate_t;

  typedef struct packed {
    mstate_t                    s;
    res_t [MaxResults-1:0]      r;
    logic [CntW-1:0]            n;
    logic                       ended;
  } acc_t;

  // Run of results handed from the splitter core to the output buffer.
  typedef struct packed {
    logic                  load;
    logic [CntW-1:0]       n;
    res_t [MaxResults-1:0] r;
  } burst_t;

  function automatic res_t mk_res(logic [1:0] kind, logic [7:0] ch, logic [4:0] cmd,
                                  logic st, logic [7:0] len);
    res_t x;
    x.kind = kind;
    x.ch   = ch;
    x.cmd  = cmd;
    x.st   = st;
    x.len  = len;
    return x;
  endfunction

  function automatic acc_t emit(acc_t a, res_t x);
    acc_t o;
    o = a;
    if (a.n < CntW'(MaxResults)) begin
      o.r[a.n] = x;
      o.n = a.n + 1'b1;
    end
    return o;
  endfunction

  function automatic acc_t literal(acc_t a, logic [7:0] c);
    acc_t o;
    o = emit(a, mk_res(KIND_BYTE, c, 5'd0, 1'b0, 8'd0));
    o.s.line_len = o.s.line_len + 8'd1;
    return o;
  endfunction

  // One byte of text, with the line length check ahead of everything else.
  function automatic acc_t take(acc_t a, logic [7:0] c, logic at_end, logic [7:0] max_len);
    acc_t o;
    o = a;
    if (!a.ended) begin
      if (a.s.line_len >= max_len) begin
        o = emit(o, mk_res(KIND_MACRO_END, 8'd0, 5'd0, 1'b1, 8'd0));
        o.ended = 1'b1;
      end else if (c == CH_ESCAPE && !at_end) begin
        o.s.esc = 1'b1;
        o.s.held_one = 1'b0;
      end else if (c == CH_AMP || c == CH_NEWLINE) begin
        if (a.s.line_len == 8'd0) begin
          o = emit(o, mk_res(KIND_MACRO_END, 8'd0, 5'd0, 1'b0, 8'd0));
          o.ended = 1'b1;
        end else begin
          o = emit(o, mk_res(KIND_LINE_END, 8'd0, 5'd0, 1'b0, a.s.line_len));
          o.s.line_len = 8'd0;
        end
      end else begin
        o = literal(o, c);
      end
    end
    return o;
  endfunction

  // Replay of a held byte after an unmatched escape. At this point an escape
  // can only be freshly opened, so the byte is simply held.
  function automatic acc_t feed_replay(acc_t a, logic [7:0] c, logic [7:0] max_len);
    acc_t o;
    o = a;
    if (!a.ended) begin
      if (a.s.esc) begin
        o.s.held0 = c;
        o.s.held_one = 1'b1;
      end else begin
        o = take(a, c, 1'b0, max_len);
      end
    end
    return o;
  endfunction

  // Returns {hit, index}.
  function automatic logic [5:0] match_code(logic [7:0] b0, logic [7:0] b1);
    logic       hit;
    logic [4:0] idx;
    hit = 1'b0;
    idx = 5'd0;
    for (int i = 0; i < NumCodes; i++) begin
      if (!hit && CodeTable[i] == {b0, b1}) begin
        hit = 1'b1;
        idx = 5'(i);
      end
    end
    return {hit, idx};
  endfunction

endpackage

// ===== rtl/mls_out_buf.sv =====
// Output buffer of the macro line splitter: holds the run of results of one
// byte and hands them out one transfer at a time. Depends on mls_pkg.
module mls_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  mls_pkg::burst_t burst,
  output logic           can_load,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [23:0]    m_tdata,  // char_out, command_code, end_status, line_length, zero pad
  output logic [1:0]     m_tuser,  // result_kind
  output logic           m_tlast   // last_of_run
);
  import mls_pkg::*;

  logic [CntW-1:0]       count;
  res_t [MaxResults-1:0] list;
  res_t                  head;
  logic                  taken;
  logic                  load;

  assign head     = list[0];
  assign m_tvalid = (count != '0);
  assign taken    = m_tvalid && m_tready;
  assign can_load = (count == '0) || (count == CntW'(1) && m_tready);
  assign load     = burst.load && can_load;

  assign m_tdata = {2'b00, head.len, head.st, head.cmd, head.ch};
  assign m_tuser = head.kind;
  assign m_tlast = (count == CntW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= burst.n;
    end else if (taken) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      list <= burst.r;
    end else if (taken) begin
      list <= {res_t'(0), list[MaxResults-1:1]};
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(MaxResults))
    else $error("output buffer holds more results than one byte can cause");

  a_run_drains: assert property (@(posedge clk) disable iff (rst)
    (taken && m_tlast && !burst.load) |=> !m_tvalid)
    else $error("results remain after the last of a run was taken");

endmodule

// ===== rtl/macro_line_splitter_with_escapes.sv =====
// Top level of the macro line splitter with realtime escapes: input register,
// splitter state, length register and the output buffer.
// Depends on mls_pkg and mls_out_buf.
//
//  Channel  | Direction | Handshake          | Contents
//  ---------+-----------+--------------------+------------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tdata[7:0] char_in, tlast final_byte
//  m_*      | out       | m_tvalid/m_tready  | tdata char_out/command_code/end_status/
//           |           |                    | line_length, tuser result_kind,
//           |           |                    | tlast last_of_run
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_data max_line_len
//
// A byte is taken into the input register and processed from there once the
// output buffer is empty or hands out its final result in that same cycle.
// A byte that causes k results occupies the output side until all k are taken,
// so the sustained rate is one byte per cycle while each byte causes at most
// one result and the output does not stall.
// Reset clears the splitter state and sets max_line_len to 255; a stall on
// the result side reaches s_tready combinationally once the input register is full.
module macro_line_splitter_with_escapes (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_in
  input  logic        s_tlast,   // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // char_out[7:0], command_code[12:8], end_status[13],
                                 // line_length[21:14], zero pad[23:22]
  output logic [1:0]  m_tuser,   // result_kind
  output logic        m_tlast,   // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data   // max_line_len
);
  import mls_pkg::*;

  // Configuration: always ready; user's rule: written only while the block is idle.
  logic [7:0] max_line_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_len <= MaxLineLenReset;
    end else if (cfg_valid) begin
      max_line_len <= cfg_data;
    end
  end

  // Input register, which parts the input side from the output buffer.
  logic       ib_valid;
  logic [7:0] ib_char;
  logic       ib_fin;
  logic       can_load;
  logic       consume;

  assign consume  = ib_valid && can_load;
  assign s_tready = !ib_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (s_tready) begin
      ib_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ib_char <= s_tdata;
      ib_fin  <= s_tlast;
    end
  end

  // Splitter state: escape tracking, the byte held after an escape, the
  // length of the open line, and whether the macro has already ended.
  mstate_t    st;
  logic       macro_done;
  acc_t       acc;
  logic       macro_done_next;
  logic [5:0] code_hit;
  logic       rem_held;
  logic [7:0] rem_byte;
  burst_t     burst;

  always_comb begin
    acc             = '0;
    acc.s           = st;
    macro_done_next = macro_done;
    code_hit        = match_code(st.held0, ib_char);
    rem_held        = 1'b0;
    rem_byte        = 8'd0;
    if (macro_done) begin
      // Everything up to the final byte of the string is dropped.
      if (ib_fin) begin
        acc.s           = '0;
        macro_done_next = 1'b0;
      end
    end else begin
      if (!st.esc) begin
        acc = take(acc, ib_char, 1'b0, max_line_len);
      end else if (!st.held_one) begin
        acc.s.held0    = ib_char;
        acc.s.held_one = 1'b1;
      end else begin
        // Second byte after the escape: either a realtime command, or a
        // literal '#' followed by a replay of both held bytes.
        acc.s.esc      = 1'b0;
        acc.s.held_one = 1'b0;
        if (code_hit[5]) begin
          acc = emit(acc, mk_res(KIND_COMMAND, 8'd0, code_hit[4:0], 1'b0, 8'd0));
        end else begin
          acc = literal(acc, CH_ESCAPE);
          acc = feed_replay(acc, st.held0, max_line_len);
          acc = feed_replay(acc, ib_char, max_line_len);
        end
      end

      if (!acc.ended && ib_fin) begin
        // End of the string: an open escape becomes literal text, the open
        // line is closed and the macro ends.
        if (acc.s.esc) begin
          rem_held       = acc.s.held_one;
          rem_byte       = acc.s.held0;
          acc.s.esc      = 1'b0;
          acc.s.held_one = 1'b0;
          acc = literal(acc, CH_ESCAPE);
          if (rem_held) begin
            acc = take(acc, rem_byte, 1'b1, max_line_len);
          end
        end
        if (!acc.ended) begin
          if (acc.s.line_len != 8'd0) begin
            acc = emit(acc, mk_res(KIND_LINE_END, 8'd0, 5'd0, 1'b0, acc.s.line_len));
          end
          acc = emit(acc, mk_res(KIND_MACRO_END, 8'd0, 5'd0, 1'b0, 8'd0));
        end
        acc.ended = 1'b1;
      end

      if (acc.ended) begin
        acc.s           = '0;
        macro_done_next = !ib_fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= '0;
      macro_done <= 1'b0;
    end else if (consume) begin
      st         <= acc.s;
      macro_done <= macro_done_next;
    end
  end

  assign burst.load = consume;
  assign burst.n    = acc.n;
  assign burst.r    = acc.r;

  mls_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .burst    (burst),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_done_is_clean: assert property (@(posedge clk) disable iff (rst)
    macro_done |-> (st.line_len == 8'd0 && !st.esc && !st.held_one))
    else $error("ended macro still carries line or escape state");

  a_stall_needs_byte: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> ib_valid)
    else $error("input stalled with an empty input register");

  a_held_needs_escape: assert property (@(posedge clk) disable iff (rst)
    st.held_one |-> st.esc)
    else $error("byte held without an open escape");

endmodule

// ===== tb/tb_macro_line_splitter_with_escapes.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for macro_line_splitter_with_escapes: a directed table, then random
// macros over several line limits, checked transfer by transfer against a built-in predictor.
// Depends on mls_pkg (result kinds) and the block's RTL; it reads no files.
module tb_macro_line_splitter_with_escapes;
  import mls_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_RUN       = 6;
  localparam int NUM_CODES     = 17;
  localparam int NUM_PHASES    = 6;

  localparam logic [7:0] HASH = 8'h23;
  localparam logic [7:0] AMP  = 8'h26;
  localparam logic [7:0] NL   = 8'h0A;

  // Realtime escape codes in command order, first character in the upper byte.
  localparam logic [15:0] ESCAPE_CODES [NUM_CODES] = '{
    "fr", "f>", "f<", "f+", "f-", "rr", "rm", "rl", "rx",
    "sr", "s>", "s<", "s+", "s-", "ss", "ft", "mt"
  };

  // How the results of one text byte are known: from the predictor, or typed into the table.
  typedef enum logic [1:0] {BY_MODEL, NO_RESULT, ONE_RESULT} row_check_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [4:0] cmd;
    logic       st;
    logic [7:0] len;
    logic       last;
  } result_t;

  // One byte of macro text; the typed result fields only matter for ONE_RESULT rows.
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    row_check_e check;
    logic [1:0] kind;
    logic [7:0] out_ch;
    logic [4:0] cmd;
    logic       st;
    logic [7:0] len;
  } text_byte_t;

  // Directed table, walked in order straight after reset (line limit still at 255).
  localparam int NUM_DIRECTED = 23;
  localparam text_byte_t DIRECTED [NUM_DIRECTED] = '{
    // An empty first line ends the macro at once.
    '{AMP,    1'b0, ONE_RESULT, KIND_MACRO_END, 8'h00, 5'd0,  1'b0, 8'd0},
    // The rest of an ended macro is ignored up to its final byte.
    '{"x",    1'b1, NO_RESULT,  KIND_BYTE,      8'h00, 5'd0,  1'b0, 8'd0},
    '{8'h00,  1'b0, ONE_RESULT, KIND_BYTE,      8'h00, 5'd0,  1'b0, 8'd0},
    '{8'hFF,  1'b0, ONE_RESULT, KIND_BYTE,      8'hFF, 5'd0,  1'b0, 8'd0},
    '{NL,     1'b0, ONE_RESULT, KIND_LINE_END,  8'h00, 5'd0,  1'b0, 8'd2},
    // First and last entries of the command table.
    '{HASH,   1'b0, NO_RESULT,  KIND_BYTE,      8'h00, 5'd0,  1'b0, 8'd0},
    '{"f",    1'b0, NO_RESULT,  KIND_BYTE,      8'h00, 5'd0,  1'b0, 8'd0},
    '{"r",    1'b0, ONE_RESULT, KIND_COMMAND,   8'h00, 5'd0,  1'b0, 8'd0},
    '{HASH,   1'b0, NO_RESULT,  KIND_BYTE,      8'h00, 5'd0,  1'b0, 8'd0},
    '{"m",    1'b0, NO_RESULT,  KIND_BYTE,      8'h00, 5'd0,  1'b0, 8'd0},
    '{"t",    1'b0, ONE_RESULT, KIND_COMMAND,   8'h00, 5'd16, 1'b0, 8'd0},
    // Unmatched escape: the '#' goes out as text and both held bytes are replayed.
    '{HASH,   1'b0, BY_MODEL,   KIND_BYTE,      8'h00, 5'd0,  1'b0, 8'd0},
    '{"x",    1'b0, BY_MODEL,   KIND_BYTE,      8'h00, 5'd0,  1'b0, 8'd0},
    '{"y",    1'b0, BY_MODEL,   KIND_BYTE,      8'h00, 5'd0,  1'b0, 8'd0},
    // A replayed '#' opens a fresh escape, which then matches.
    '{HASH,   1'b0, BY_MODEL,   KIND_BYTE,      8'h00, 5'd0,  1'b0, 8'd0},
    '{HASH,   1'b0, BY_MODEL,   KIND_BYTE,      8'h00, 5'd0,  1'b0, 8'd0},
    '{"f",    1'b0, BY_MODEL,   KIND_BYTE,      8'h00, 5'd0,  1'b0, 8'd0},
    '{"r",    1'b0, BY_MODEL,   KIND_BYTE,      8'h00, 5'd0,  1'b0, 8'd0},
    // Escapes cut short by the end of the string are plain text.
    '{HASH,   1'b0, BY_MODEL,   KIND_BYTE,      8'h00, 5'd0,  1'b0, 8'd0},
    '{"a",    1'b1, BY_MODEL,   KIND_BYTE,      8'h00, 5'd0,  1'b0, 8'd0},
    '{HASH,   1'b0, BY_MODEL,   KIND_BYTE,      8'h00, 5'd0,  1'b0, 8'd0},
    '{HASH,   1'b1, BY_MODEL,   KIND_BYTE,      8'h00, 5'd0,  1'b0, 8'd0},
    '{HASH,   1'b1, BY_MODEL,   KIND_BYTE,      8'h00, 5'd0,  1'b0, 8'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'd0;

  macro_line_splitter_with_escapes dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted splitter state; it starts from the reset values of the block.
  logic [7:0] line_limit = 8'd255;
  logic [7:0] held [2] = '{8'd0, 8'd0};
  logic [1:0] held_n = 2'd0;
  bit         esc_open = 1'b0;
  logic [7:0] line_n = 8'd0;
  bit         macro_over = 1'b0;

  result_t    step_results[$];
  result_t    pending_results[$];
  text_byte_t bytes_to_send[$];
  text_byte_t offered;

  bit  in_flight = 1'b0;
  int  send_gap = 0;
  int  ready_wait = 0;
  int  quiet_left = 0;
  int  stall_asks = 0;
  int  stall_seen = 0;
  int  cycles = 0;
  int  fails = 0;

  task automatic report(input string what);
    $display("ERROR at cycle %0d: %s", cycles, what);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Mostly no gap, now and then a short one, rarely a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic put_result(input logic [1:0] kind, input logic [7:0] ch, input logic [4:0] cmd,
                            input logic st, input logic [7:0] len);
    result_t r;
    r.kind = kind;
    r.ch   = ch;
    r.cmd  = cmd;
    r.st   = st;
    r.len  = len;
    r.last = 1'b0;
    if (step_results.size() < MAX_RUN) step_results.push_back(r);
  endtask

  task automatic add_char(input logic [7:0] c);
    put_result(KIND_BYTE, c, 5'd0, 1'b0, 8'd0);
    line_n = line_n + 8'd1;
  endtask

  task automatic clear_macro();
    held[0]  = 8'd0;
    held[1]  = 8'd0;
    held_n   = 2'd0;
    esc_open = 1'b0;
    line_n   = 8'd0;
  endtask

  // One byte taken as text. The length check comes ahead of everything, separators included.
  task automatic take_byte(input logic [7:0] c, input bit at_end, output bit ended);
    ended = 1'b0;
    if (line_n >= line_limit) begin
      put_result(KIND_MACRO_END, 8'd0, 5'd0, 1'b1, 8'd0);
      ended = 1'b1;
    end else if (c == HASH && !at_end) begin
      esc_open = 1'b1;
      held_n   = 2'd0;
    end else if (c == AMP || c == NL) begin
      if (line_n == 8'd0) begin
        put_result(KIND_MACRO_END, 8'd0, 5'd0, 1'b0, 8'd0);
        ended = 1'b1;
      end else begin
        put_result(KIND_LINE_END, 8'd0, 5'd0, 1'b0, line_n);
        line_n = 8'd0;
      end
    end else begin
      add_char(c);
    end
  endtask

  // Works out the run of results that one accepted text byte causes, into step_results.
  task automatic split_byte(input logic [7:0] c, input logic fin);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] n;
    int         code;
    bit         ended;
    ended = 1'b0;
    step_results.delete();
    if (macro_over) begin
      // Waiting for the final byte of a macro that has already ended.
      if (fin) begin
        clear_macro();
        macro_over = 1'b0;
      end
    end else begin
      if (!esc_open) begin
        take_byte(c, 1'b0, ended);
      end else begin
        held[held_n[0]] = c;
        held_n = held_n + 2'd1;
        if (held_n == 2'd2) begin
          b0 = held[0];
          b1 = held[1];
          esc_open = 1'b0;
          held_n = 2'd0;
          code = -1;
          for (int i = 0; i < NUM_CODES; i++) begin
            if (code < 0 && ESCAPE_CODES[i] == {b0, b1}) code = i;
          end
          if (code >= 0) begin
            put_result(KIND_COMMAND, 8'd0, 5'(code), 1'b0, 8'd0);
          end else begin
            // No match: the '#' is text and the held pair is replayed. A replayed '#' opens a
            // new escape, and the second byte is then simply held.
            add_char(HASH);
            take_byte(b0, 1'b0, ended);
            if (!ended && esc_open) begin
              held[0] = b1;
              held_n = 2'd1;
            end else if (!ended) begin
              take_byte(b1, 1'b0, ended);
            end
          end
        end
      end
      if (!ended && fin) begin
        // End of the string: an open escape turns into text, then the line and macro close.
        if (esc_open) begin
          n  = (held_n > 2'd2) ? 2'd2 : held_n;
          b0 = held[0];
          b1 = held[1];
          esc_open = 1'b0;
          held_n = 2'd0;
          add_char(HASH);
          if (n > 2'd0) take_byte(b0, 1'b1, ended);
          if (!ended && n > 2'd1) take_byte(b1, 1'b1, ended);
        end
        if (!ended) begin
          if (line_n > 8'd0) put_result(KIND_LINE_END, 8'd0, 5'd0, 1'b0, line_n);
          put_result(KIND_MACRO_END, 8'd0, 5'd0, 1'b0, 8'd0);
        end
        ended = 1'b1;
      end
      if (ended) begin
        clear_macro();
        macro_over = !fin;
      end
    end
    if (step_results.size() > 0) step_results[$].last = 1'b1;
  endtask

  // Queues one random macro and returns how many bytes it holds. Most are well-formed lines of
  // text, commands and broken escapes; some are raw noise.
  task automatic queue_macro(output int count);
    logic [7:0] text[$];
    text_byte_t item;
    int         lines;
    int         segs;
    int         pick;
    int         code;
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      lines = $urandom_range(1, 4);
      for (int l = 0; l < lines; l++) begin
        if (l > 0) text.push_back($urandom_range(0, 1) ? AMP : NL);
        // Now and then an empty line, which ends the macro early.
        segs = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
        repeat (segs) begin
          pick = $urandom_range(0, 9);
          code = $urandom_range(0, NUM_CODES - 1);
          if (pick < 4) begin
            text.push_back(8'($urandom_range(8'h20, 8'h7E)));
          end else if (pick < 7) begin
            text.push_back(HASH);
            text.push_back(ESCAPE_CODES[code][15:8]);
            text.push_back(ESCAPE_CODES[code][7:0]);
          end else if (pick == 7) begin
            text.push_back(HASH);
            text.push_back(ESCAPE_CODES[code][15:8]);
            text.push_back(8'($urandom_range(0, 255)));
          end else if (pick == 8) begin
            text.push_back(8'($urandom_range(0, 255)));
          end else begin
            text.push_back(HASH);
            text.push_back(HASH);
            text.push_back(ESCAPE_CODES[code][15:8]);
            text.push_back(ESCAPE_CODES[code][7:0]);
          end
        end
      end
      // An escape that the end of the string cuts short.
      if ($urandom_range(0, 3) == 0) text.push_back(HASH);
    end
    if (text.size() == 0) text.push_back(8'($urandom_range(0, 255)));
    foreach (text[i]) begin
      item = '0;
      item.ch = text[i];
      item.fin = (i == text.size() - 1);
      item.check = BY_MODEL;
      bytes_to_send.push_back(item);
    end
    count = text.size();
  endtask

  // Holds the stimulus back until every queued byte is taken and every result has come out,
  // then lets the block settle, since a byte with no result may still be in its pipeline.
  task automatic wait_for_drain();
    while (bytes_to_send.size() > 0 || in_flight || pending_results.size() > 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Cycle count, quiet stretches with no idling on either side, and the run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (quiet_left > 0) begin
      quiet_left = quiet_left - 1;
    end else if ($urandom_range(0, 63) == 0) begin
      quiet_left = $urandom_range(20, 60);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sender: offers queued bytes at the falling edge and keeps each one up until its transfer.
  always @(negedge clk) begin
    if (!rst && !in_flight) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (bytes_to_send.size() > 0) begin
        offered = bytes_to_send.pop_front();
        s_tdata <= offered.ch;
        s_tlast <= offered.fin;
        s_tvalid <= 1'b1;
        in_flight = 1'b1;
        send_gap = (quiet_left > 0) ? 0 : pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request while the sender keeps going.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_asks != stall_seen) begin
      stall_seen = stall_asks;
      ready_wait = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else if (ready_wait > 0) begin
      ready_wait = ready_wait - 1;
      m_tready <= 1'b0;
    end else if (quiet_left == 0 && $urandom_range(0, 3) == 0) begin
      ready_wait = pick_gap();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // At each rising edge: check a result transfer against the oldest expectation, and predict
  // the results of an input transfer.
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report($sformatf("result with none expected: kind %0d data %h", m_tuser, m_tdata));
        end else begin
          want = pending_results.pop_front();
          check_field("result_kind", 8'(m_tuser), 8'(want.kind));
          check_field("char_out", m_tdata[7:0], want.ch);
          check_field("command_code", 8'(m_tdata[12:8]), 8'(want.cmd));
          check_field("end_status", 8'(m_tdata[13]), 8'(want.st));
          check_field("line_length", m_tdata[21:14], want.len);
          check_field("tdata padding", 8'(m_tdata[23:22]), 8'd0);
          check_field("last_of_run", 8'(m_tlast), 8'(want.last));
        end
      end
      if (s_tvalid && s_tready) begin
        split_byte(offered.ch, offered.fin);
        case (offered.check)
          BY_MODEL: begin
            foreach (step_results[i]) pending_results.push_back(step_results[i]);
          end
          ONE_RESULT: begin
            pending_results.push_back({offered.kind, offered.out_ch, offered.cmd, offered.st,
                                       offered.len, 1'b1});
          end
          default: begin
          end
        endcase
        in_flight = 1'b0;
      end
    end
  end

  // Line limits per phase, the extremes among them; phase 4 draws its own value. Byte budgets
  // are small where the limit makes most of each macro be ignored.
  int phase_limit [NUM_PHASES] = '{255, 1, 0, 3, -1, 255};
  int phase_bytes [NUM_PHASES] = '{25, 10, 6, 20, 22, 25};

  initial begin : stimulus
    int queued;
    int added;
    logic [7:0] limit;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) bytes_to_send.push_back(DIRECTED[i]);
    wait_for_drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      // The block is idle here, so the line limit may be changed.
      limit = (phase_limit[p] < 0) ? 8'($urandom_range(4, 12)) : 8'(phase_limit[p]);
      cfg_data <= limit;
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      line_limit = limit;
      @(negedge clk);
      cfg_valid <= 1'b0;

      queued = 0;
      while (queued < phase_bytes[p]) begin
        queue_macro(added);
        queued += added;
      end
      // With short lines under a limit of 3 results pile up; hold the output back as well so
      // that the block fills and stalls its input.
      if (p == 3) stall_asks++;
      wait_for_drain();
    end

    repeat (8) @(negedge clk);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== macro_line_splitter_with_escapes.f =====
rtl/mls_pkg.sv
rtl/mls_out_buf.sv
rtl/macro_line_splitter_with_escapes.sv
tb/tb_macro_line_splitter_with_escapes.sv
